@@ hdl/word_frequency_table_defines.svh @@
// Assertion macros shared by the word frequency table RTL.
`ifndef WORD_FREQUENCY_TABLE_DEFINES_SVH
`define WORD_FREQUENCY_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define WFT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WFT_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WFT_ASSERT(label, clk, rst, prop, msg)
`define WFT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ hdl/wft_pkg.sv @@
// Package with the shared types and constants of the word frequency table.
package wft_pkg;
   localparam int TABLE_DEPTH  = 64;
   localparam int MAX_WORD_LEN = 24;
   localparam int COUNT_WIDTH  = 16;
   localparam int IDX_W        = $clog2(TABLE_DEPTH);
   localparam int USED_W       = $clog2(TABLE_DEPTH + 1);
   localparam int LEN_W        = 5;
   localparam int WORD_W       = 192;
   localparam int ENTRY_W      = WORD_W + LEN_W + COUNT_WIDTH;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_NUL     = 8'h00;

   typedef enum logic {
      CMD_TEXT = 1'b0,
      CMD_DUMP = 1'b1
   } cmd_type;

   typedef struct packed {
      logic               dump;
      logic               has_word;
      logic               trunc;
      logic [LEN_W-1:0]   length;
      logic [WORD_W-1:0]  word;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_CHECK,
      ST_DUMP_READ,
      ST_DUMP_SEND,
      ST_EMPTY_SEND
   } back_state_type;
endpackage

@@ hdl/word_frequency_table.sv @@
// Top level of the word frequency table with stream ports and the register port.
// Text bytes are taken one per cycle into the word assembler while its four-entry
// queue has room; for each closed word the table engine visits the stored entries in
// order, each with a registered RAM read and then a compare, until it finds a match,
// appends the word, or flags overflow when full. An end-of-text command closes the
// open word, then streams one result per stored entry, or a single invalid result
// for an empty table, and clears the table. No clearing pass is needed after reset.
module word_frequency_table (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // char_byte[7:0]
   input  logic         req_tuser,   // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [215:0] rsp_tdata,   // word_part_low, word_part_mid, word_part_high,
                                     // word_length[4:0], occurrences[15:0], zeros[2:0]
   output logic [2:0]   rsp_tuser,   // entry_valid, table_overflowed, word_truncated
   output logic         rsp_tlast,   // last_entry
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   logic             fold_case_ff;
   logic             job_valid, job_ready;
   wft_pkg::job_type job;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? {31'd0, fold_case_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_case_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0) begin
         fold_case_ff <= csr_pwdata[0];
      end
   end

   wft_front u_front (
      .clock      (clock),
      .reset      (reset),
      .fold_case  (fold_case_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_command (req_tuser),
      .in_char    (req_tdata),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job)
   );

   wft_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_user  (rsp_tuser),
      .out_last  (rsp_tlast)
   );
endmodule

@@ hdl/wft_ram.sv @@
// Generic single-port-write, registered-read RAM.
module wft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ hdl/wft_front.sv @@
// Front end: assembles words from the byte stream and queues closed words and dumps.
module wft_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fold_case,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic                 in_command,
   input  logic [7:0]           in_char,
   output logic                 job_valid,
   input  logic                 job_ready,
   output wft_pkg::job_type     job
);
   `include "word_frequency_table_defines.svh"

   localparam int QW = $clog2(wft_pkg::QUEUE_DEPTH);

   logic [7:0]              word_ff [wft_pkg::MAX_WORD_LEN];
   logic [7:0]              char_in;
   logic [wft_pkg::LEN_W-1:0] fill_ff, fill_in;
   logic                    trunc_ff, trunc_in;
   wft_pkg::job_type        q_ff [wft_pkg::QUEUE_DEPTH];
   logic [QW-1:0]           wp_ff, rp_ff;
   logic [QW:0]             cnt_ff, cnt_in;
   logic                    push, pop, accept, is_delim, is_byte;
   wft_pkg::job_type        new_job;

   assign in_ready  = (cnt_ff != (QW+1)'(wft_pkg::QUEUE_DEPTH));
   assign accept    = in_valid && in_ready;
   assign is_delim  = (in_char == wft_pkg::CHAR_SPACE) || (in_char == wft_pkg::CHAR_TAB)
                      || (in_char == wft_pkg::CHAR_NEWLINE);
   assign is_byte   = !is_delim && (in_char != wft_pkg::CHAR_NUL);
   assign job_valid = (cnt_ff != '0);
   assign job       = q_ff[rp_ff];
   assign pop       = job_valid && job_ready;

   always_comb begin
      char_in = in_char;
      if (fold_case && in_char >= 8'h41 && in_char <= 8'h5A) begin
         char_in = in_char + 8'h20;
      end
      new_job.dump     = (in_command == wft_pkg::CMD_DUMP);
      new_job.has_word = (fill_ff != '0);
      new_job.trunc    = trunc_ff;
      new_job.length   = fill_ff;
      for (int i = 0; i < wft_pkg::MAX_WORD_LEN; i++) begin
         new_job.word[i*8 +: 8] = (wft_pkg::LEN_W'(i) < fill_ff) ? word_ff[i] : 8'h00;
      end
      for (int i = wft_pkg::MAX_WORD_LEN; i < 24; i++) begin
         new_job.word[i*8 +: 8] = 8'h00;
      end
      push     = 1'b0;
      fill_in  = fill_ff;
      trunc_in = trunc_ff;
      if (accept) begin
         if (in_command == wft_pkg::CMD_DUMP) begin
            push     = 1'b1;
            fill_in  = '0;
            trunc_in = 1'b0;
         end else if (is_delim) begin
            push    = (fill_ff != '0);
            fill_in = '0;
         end else if (is_byte) begin
            if (fill_ff < wft_pkg::LEN_W'(wft_pkg::MAX_WORD_LEN)) begin
               fill_in = fill_ff + 1'b1;
            end else begin
               trunc_in = 1'b1;
            end
         end
      end
      cnt_in = cnt_ff + (QW+1)'(push) - (QW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         trunc_ff <= 1'b0;
         wp_ff    <= '0;
         rp_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         fill_ff  <= fill_in;
         trunc_ff <= trunc_in;
         cnt_ff   <= cnt_in;
         if (push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_command == wft_pkg::CMD_TEXT && is_byte
          && fill_ff < wft_pkg::LEN_W'(wft_pkg::MAX_WORD_LEN)) begin
         word_ff[fill_ff[$clog2(wft_pkg::MAX_WORD_LEN)-1:0]] <= char_in;
      end
      if (push) begin
         q_ff[wp_ff] <= new_job;
      end
   end

   `WFT_ASSERT(a_fill_max, clock, reset,
      fill_ff <= wft_pkg::LEN_W'(wft_pkg::MAX_WORD_LEN), "word fill exceeds maximum")
   `WFT_ASSERT(a_cnt_max, clock, reset,
      cnt_ff <= (QW+1)'(wft_pkg::QUEUE_DEPTH), "queue count exceeds depth")
   `WFT_ASSERT(a_no_push_full, clock, reset,
      (cnt_ff == (QW+1)'(wft_pkg::QUEUE_DEPTH)) |-> !push, "push into full queue")
endmodule

@@ hdl/wft_back.sv @@
// Back end: searches the table, updates counts, appends words and dumps the table.
module wft_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  wft_pkg::job_type     job,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [215:0]         out_data,
   output logic [2:0]           out_user,
   output logic                 out_last
);
   `include "word_frequency_table_defines.svh"

   wft_pkg::back_state_type         state_ff, state_in;
   logic [wft_pkg::USED_W-1:0]      used_ff, used_in;
   logic [wft_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic                            ovf_ff, ovf_in, trc_ff, trc_in;
   wft_pkg::job_type                cur_ff;
   logic                            take;
   logic                            wr_en;
   logic [wft_pkg::IDX_W-1:0]       wr_addr, rd_addr;
   logic [wft_pkg::ENTRY_W-1:0]     wr_data, rd_data;
   logic [wft_pkg::WORD_W-1:0]      rd_word;
   logic [wft_pkg::LEN_W-1:0]       rd_len;
   logic [wft_pkg::COUNT_WIDTH-1:0] rd_cnt, cnt_max;
   logic                            hit, last_idx;
   logic [15:0]                     occ;

   wft_ram #(.WIDTH(wft_pkg::ENTRY_W), .DEPTH(wft_pkg::TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_word  = rd_data[wft_pkg::WORD_W-1:0];
   assign rd_len   = rd_data[wft_pkg::WORD_W +: wft_pkg::LEN_W];
   assign rd_cnt   = rd_data[wft_pkg::WORD_W + wft_pkg::LEN_W +: wft_pkg::COUNT_WIDTH];
   assign cnt_max  = '1;
   assign hit      = (rd_len == cur_ff.length) && (rd_word == cur_ff.word);
   assign last_idx = (wft_pkg::USED_W'(idx_ff) + 1'b1 == used_ff);
   assign take     = job_valid && job_ready;

   always_comb begin
      if (wft_pkg::COUNT_WIDTH > 16 && rd_cnt > wft_pkg::COUNT_WIDTH'(16'hFFFF)) begin
         occ = 16'hFFFF;
      end else begin
         occ = 16'(rd_cnt);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wft_pkg::ST_IDLE: begin
            if (take) begin
               if (job.has_word) begin
                  state_in = (used_ff == '0) ? wft_pkg::ST_CHECK : wft_pkg::ST_SEARCH;
               end else if (used_ff == '0) begin
                  state_in = wft_pkg::ST_EMPTY_SEND;
               end else begin
                  state_in = wft_pkg::ST_DUMP_READ;
               end
            end
         end
         wft_pkg::ST_SEARCH: state_in = wft_pkg::ST_CHECK;
         wft_pkg::ST_CHECK: begin
            if (used_ff != '0 && hit) begin
               state_in = cur_ff.dump ? wft_pkg::ST_DUMP_READ : wft_pkg::ST_IDLE;
            end else if (used_ff != '0 && !last_idx) begin
               state_in = wft_pkg::ST_SEARCH;
            end else begin
               state_in = cur_ff.dump ? wft_pkg::ST_DUMP_READ : wft_pkg::ST_IDLE;
            end
         end
         wft_pkg::ST_DUMP_READ: state_in = wft_pkg::ST_DUMP_SEND;
         wft_pkg::ST_DUMP_SEND: begin
            if (out_ready) begin
               state_in = last_idx ? wft_pkg::ST_IDLE : wft_pkg::ST_DUMP_READ;
            end
         end
         wft_pkg::ST_EMPTY_SEND: begin
            if (out_ready) begin
               state_in = wft_pkg::ST_IDLE;
            end
         end
         default: state_in = wft_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath control.
   always_comb begin
      job_ready = 1'b0;
      out_valid = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = {rd_cnt, rd_len, rd_word};
      rd_addr   = idx_ff;
      idx_in    = idx_ff;
      used_in   = used_ff;
      ovf_in    = ovf_ff;
      trc_in    = trc_ff;
      out_data  = '0;
      out_user  = '0;
      out_last  = 1'b0;
      case (state_ff)
         wft_pkg::ST_IDLE: begin
            job_ready = 1'b1;
            idx_in    = '0;
            if (take) begin
               trc_in = trc_ff | job.trunc;
            end
         end
         wft_pkg::ST_SEARCH: begin
         end
         wft_pkg::ST_CHECK: begin
            if (used_ff != '0 && hit) begin
               wr_en   = 1'b1;
               wr_data = {(rd_cnt == cnt_max) ? rd_cnt : rd_cnt + 1'b1, rd_len, rd_word};
               idx_in  = '0;
            end else if (used_ff != '0 && !last_idx) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               idx_in = '0;
               if (used_ff == wft_pkg::USED_W'(wft_pkg::TABLE_DEPTH)) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = used_ff[wft_pkg::IDX_W-1:0];
                  wr_data = {wft_pkg::COUNT_WIDTH'(1), cur_ff.length, cur_ff.word};
                  used_in = used_ff + 1'b1;
               end
            end
         end
         wft_pkg::ST_DUMP_READ: begin
         end
         wft_pkg::ST_DUMP_SEND: begin
            out_valid = 1'b1;
            out_data  = {3'd0, occ, rd_len, rd_word};
            out_user  = {trc_ff, ovf_ff, 1'b1};
            out_last  = last_idx;
            if (out_ready) begin
               idx_in = idx_ff + 1'b1;
               if (last_idx) begin
                  used_in = '0;
                  ovf_in  = 1'b0;
                  trc_in  = 1'b0;
               end
            end
         end
         wft_pkg::ST_EMPTY_SEND: begin
            out_valid = 1'b1;
            out_user  = {trc_ff, ovf_ff, 1'b0};
            out_last  = 1'b1;
            if (out_ready) begin
               ovf_in = 1'b0;
               trc_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wft_pkg::ST_IDLE;
         used_ff  <= '0;
         idx_ff   <= '0;
         ovf_ff   <= 1'b0;
         trc_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         idx_ff   <= idx_in;
         ovf_ff   <= ovf_in;
         trc_ff   <= trc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cur_ff <= job;
      end
   end

   `WFT_ASSERT(a_used_max, clock, reset,
      used_ff <= wft_pkg::USED_W'(wft_pkg::TABLE_DEPTH), "table count exceeds depth")
   `WFT_ASSERT(a_out_in_dump, clock, reset,
      out_valid |-> (state_ff == wft_pkg::ST_DUMP_SEND || state_ff == wft_pkg::ST_EMPTY_SEND),
      "result shown outside a dump")
   `WFT_ASSERT(a_dump_clears, clock, reset,
      (out_valid && out_ready && out_last) |=> (used_ff == '0 && !ovf_ff && !trc_ff),
      "table not cleared after dump")
endmodule

@@ bench/word_frequency_table_tb.sv @@
// Self-checking testbench for the word frequency table: streamed text, checked table dumps.
module word_frequency_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 300;
   localparam int STALL_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SAT_MAX      = 65535;

   typedef struct packed {
      logic       cmd;
      logic [7:0] ch;
   } text_item_type;

   typedef struct packed {
      logic [63:0] low;
      logic [63:0] mid;
      logic [63:0] high;
      logic [4:0]  len;
      logic [15:0] occ;
      logic        valid;
      logic        last;
      logic        ovf;
      logic        trunc;
   } entry_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;   // char_byte[7:0]
   logic         req_tuser = 1'b0; // command
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [215:0] rsp_tdata;        // low, mid, high, length[4:0], occurrences, zeros[2:0]
   logic [2:0]   rsp_tuser;        // entry_valid, table_overflowed, word_truncated
   logic         rsp_tlast;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [1:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   word_frequency_table dut (.*);

   text_item_type pending_text[$];
   entry_type     dump_expected[$];
   int            send_idle = 12;
   int            recv_idle = 54;
   int            hold_gen = 0;
   int            hold_seen = 0;
   int            hold_cnt = 0;
   int            stall_cnt = 0;
   int            fail_count = 0;

   // Predictor state.
   logic [7:0]   cur_word[wft_pkg::MAX_WORD_LEN];
   int           cur_fill = 0;
   logic [191:0] tbl_word[wft_pkg::TABLE_DEPTH];
   int           tbl_len[wft_pkg::TABLE_DEPTH];
   int           tbl_count[wft_pkg::TABLE_DEPTH];
   int           tbl_used = 0;
   logic         ovf_seen = 1'b0;
   logic         trunc_seen = 1'b0;
   logic         fold_on = 1'b1;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic close_word();
      logic [191:0] pk;
      bit           hit;
      pk = '0;
      hit = 0;
      if (cur_fill == 0) return;
      for (int i = 0; i < cur_fill; i++) pk[i*8 +: 8] = cur_word[i];
      for (int i = 0; i < tbl_used && !hit; i++) begin
         if (tbl_len[i] == cur_fill && tbl_word[i] == pk) begin
            hit = 1;
            if (tbl_count[i] < SAT_MAX) tbl_count[i]++;
         end
      end
      if (!hit) begin
         if (tbl_used >= wft_pkg::TABLE_DEPTH) ovf_seen = 1'b1;
         else begin
            tbl_word[tbl_used] = pk;
            tbl_len[tbl_used] = cur_fill;
            tbl_count[tbl_used] = 1;
            tbl_used++;
         end
      end
      cur_fill = 0;
   endtask

   task automatic predict_text(input logic cmd, input logic [7:0] ch);
      entry_type  e;
      logic [7:0] c;
      c = ch;
      if (cmd == wft_pkg::CMD_TEXT) begin
         if (c == wft_pkg::CHAR_SPACE || c == wft_pkg::CHAR_TAB
             || c == wft_pkg::CHAR_NEWLINE) close_word();
         else if (c != wft_pkg::CHAR_NUL) begin
            if (fold_on && c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
            if (cur_fill < wft_pkg::MAX_WORD_LEN) begin
               cur_word[cur_fill] = c;
               cur_fill++;
            end else trunc_seen = 1'b1;
         end
      end else begin
         close_word();
         if (tbl_used == 0) begin
            e = '0;
            e.last = 1'b1;
            e.ovf = ovf_seen;
            e.trunc = trunc_seen;
            dump_expected.push_back(e);
         end else begin
            for (int i = 0; i < tbl_used; i++) begin
               e.low = tbl_word[i][63:0];
               e.mid = tbl_word[i][127:64];
               e.high = tbl_word[i][191:128];
               e.len = 5'(tbl_len[i]);
               e.occ = 16'(tbl_count[i]);
               e.valid = 1'b1;
               e.last = (i + 1 == tbl_used);
               e.ovf = ovf_seen;
               e.trunc = trunc_seen;
               dump_expected.push_back(e);
            end
         end
         tbl_used = 0;
         ovf_seen = 1'b0;
         trunc_seen = 1'b0;
         cur_fill = 0;
      end
   endtask

   task automatic report_mismatch(input string what, input entry_type got,
                                  input entry_type want);
      $display("Mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      text_item_type t;
      if (reset) req_tvalid <= 1'b0;
      else if (!req_tvalid || req_tready) begin
         if (pending_text.size() > 0 && $urandom_range(99) >= send_idle) begin
            t = pending_text.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= t.cmd;
            req_tdata <= t.ch;
         end else req_tvalid <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_gen != hold_seen) begin
         hold_seen <= hold_gen;
         hold_cnt <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      entry_type w;
      entry_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) predict_text(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.low = rsp_tdata[63:0];
            got.mid = rsp_tdata[127:64];
            got.high = rsp_tdata[191:128];
            got.len = rsp_tdata[196:192];
            got.occ = rsp_tdata[212:197];
            got.valid = rsp_tuser[0];
            got.last = rsp_tlast;
            got.ovf = rsp_tuser[1];
            got.trunc = rsp_tuser[2];
            if (dump_expected.size() == 0)
               report_mismatch("unexpected transaction", got, '0);
            else begin
               w = dump_expected.pop_front();
               if (got !== w) report_mismatch("result", got, w);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cnt <= 0;
      else if (stall_cnt >= STALL_LIMIT) begin
         $display("Watchdog expired at %0t", $realtime);
         $display("Regression FAIL");
         $finish;
      end else stall_cnt <= stall_cnt + 1;
   end

   task automatic push_text(input logic cmd, input logic [7:0] ch);
      text_item_type t;
      t.cmd = cmd;
      t.ch = ch;
      pending_text.push_back(t);
   endtask

   task automatic push_word(input int len);
      logic [7:0] letters[4] = '{8'h61, 8'h62, 8'h41, 8'h42};
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) push_text(wft_pkg::CMD_TEXT, 8'($urandom_range(255)));
         else push_text(wft_pkg::CMD_TEXT, letters[$urandom_range(3)]);
      end
   endtask

   function automatic logic [7:0] pick_delim();
      case ($urandom_range(2))
         0: pick_delim = wft_pkg::CHAR_SPACE;
         1: pick_delim = wft_pkg::CHAR_TAB;
         default: pick_delim = wft_pkg::CHAR_NEWLINE;
      endcase
   endfunction

   task automatic push_random_text(input int n);
      int start;
      int r;
      start = pending_text.size();
      while (pending_text.size() - start < n) begin
         r = $urandom_range(99);
         if (r < 70) begin
            if ($urandom_range(29) == 0) push_word($urandom_range(25, 30));
            else push_word($urandom_range(1, 4));
            push_text(wft_pkg::CMD_TEXT, pick_delim());
         end else if (r < 80) push_text(wft_pkg::CMD_TEXT, 8'($urandom_range(255)));
         else if (r < 85) push_text(wft_pkg::CMD_TEXT, wft_pkg::CHAR_NUL);
         else if (r < 94) push_text(wft_pkg::CMD_TEXT, pick_delim());
         else push_text(wft_pkg::CMD_DUMP, 8'($urandom_range(255)));
      end
      push_text(wft_pkg::CMD_DUMP, '0);
   endtask

   task automatic write_fold(input logic v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= '0;
      csr_pwdata <= {31'b0, v};
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      fold_on = v;
   endtask

   task automatic drain();
      wait (pending_text.size() == 0 && !req_tvalid && dump_expected.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed text under the reset value of the fold register.
      send_idle = 12;
      recv_idle = 54;
      push_text(wft_pkg::CMD_DUMP, 8'hFF);
      push_text(wft_pkg::CMD_TEXT, wft_pkg::CHAR_SPACE);
      push_text(wft_pkg::CMD_TEXT, 8'h41);
      push_text(wft_pkg::CMD_TEXT, wft_pkg::CHAR_NUL);
      push_text(wft_pkg::CMD_TEXT, 8'h5A);
      push_text(wft_pkg::CMD_TEXT, wft_pkg::CHAR_TAB);
      push_text(wft_pkg::CMD_TEXT, 8'h61);
      push_text(wft_pkg::CMD_TEXT, 8'h7A);
      push_text(wft_pkg::CMD_TEXT, wft_pkg::CHAR_NEWLINE);
      push_text(wft_pkg::CMD_TEXT, wft_pkg::CHAR_NEWLINE);
      push_text(wft_pkg::CMD_TEXT, 8'hFF);
      push_text(wft_pkg::CMD_TEXT, 8'h01);
      push_text(wft_pkg::CMD_DUMP, 8'h00);
      for (int i = 0; i < wft_pkg::MAX_WORD_LEN + 1; i++)
         push_text(wft_pkg::CMD_TEXT, 8'(8'h80 + i));
      push_text(wft_pkg::CMD_DUMP, 8'h00);
      drain();

      write_fold(1'b0);
      for (int i = 0; i < wft_pkg::MAX_WORD_LEN; i++)
         push_text(wft_pkg::CMD_TEXT, 8'(8'h41 + i));
      push_text(wft_pkg::CMD_TEXT, wft_pkg::CHAR_SPACE);
      push_text(wft_pkg::CMD_TEXT, 8'h41);
      push_text(wft_pkg::CMD_TEXT, wft_pkg::CHAR_SPACE);
      push_text(wft_pkg::CMD_TEXT, 8'h61);
      push_text(wft_pkg::CMD_DUMP, 8'h00);
      drain();

      // The receiver holds off while a dump is pending and words keep coming.
      hold_gen = hold_gen + 1;
      push_word(3);
      push_text(wft_pkg::CMD_TEXT, pick_delim());
      push_text(wft_pkg::CMD_DUMP, 8'h00);
      for (int i = 0; i < 5; i++) begin
         push_word(2);
         push_text(wft_pkg::CMD_TEXT, pick_delim());
      end
      push_random_text(6);
      drain();

      write_fold(1'b1);
      send_idle = 54;
      recv_idle = 12;
      push_random_text(10);
      drain();

      // Fill the table past its depth.
      send_idle = 0;
      recv_idle = 0;
      for (int i = 0; i < wft_pkg::TABLE_DEPTH + 1; i++) begin
         push_text(wft_pkg::CMD_TEXT, 8'(8'h80 + i));
         push_text(wft_pkg::CMD_TEXT, pick_delim());
      end
      push_text(wft_pkg::CMD_TEXT, 8'h80);
      push_text(wft_pkg::CMD_DUMP, 8'h00);
      drain();

      if (dump_expected.size() != 0)
         report_mismatch("leftover expectations", '0, dump_expected[0]);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
